FILE: rtl/core/wfv_pkg.sv
package wfv_pkg;

   localparam int MAX_WAYPOINTS_DEF = 64;

   localparam int POS_W   = 24;
   localparam int DIFF_W  = 25;
   localparam int SQ_W    = 50;
   localparam int ROOT_W  = 25;
   localparam int NUM_W   = 43;
   localparam int QUO_W   = 16;
   localparam int VEL_W   = 16;
   localparam int IDX_W   = 7;
   localparam int RAD_W   = 16;
   localparam int SPD_W   = 15;
   localparam int CSR_W   = 16;

   localparam logic [RAD_W-1:0] RADIUS_RESET = 16'd77;
   localparam logic [SPD_W-1:0] SPEED_RESET  = 15'd2048;

   // fallback route, Q15.8
   localparam logic [POS_W-1:0] FB0_X = 24'd1024;
   localparam logic [POS_W-1:0] FB1_X = 24'd2048;
   localparam logic [POS_W-1:0] FB_Y  = 24'd6656;

   localparam int STEP_CNT_W = 5;
   localparam logic [STEP_CNT_W-1:0] SQRT_STEPS = 5'd25;
   localparam logic [STEP_CNT_W-1:0] DIV_STEPS  = 5'd16;

   localparam logic CSR_ARRIVAL_RADIUS = 1'b0;
   localparam logic CSR_CRUISE_SPEED   = 1'b1;

   typedef enum logic [1:0] {
      NAV_MOVING  = 2'd0,
      NAV_REACHED = 2'd1,
      NAV_DONE    = 2'd2
   } nav_status_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_TICK,
      OP_DIFF,
      OP_SQ_X,
      OP_SQ_Y,
      OP_SQ_R,
      OP_CMP,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_SCALE_X,
      OP_SCALE_Y,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_STORE_X,
      OP_STORE_Y,
      OP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic hover;
      logic near;
      logic zero;
   } dp_status_type;

endpackage

FILE: rtl/core/wfv_ctrl.sv
module wfv_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_cmd,
   output logic                  req_ready,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   input  wfv_pkg::dp_status_type status,
   output wfv_pkg::dp_cmd_type   cmd
);

   typedef enum logic [4:0] {
      ST_IDLE, ST_DIFF, ST_SQX, ST_SQY, ST_SQR, ST_CMP, ST_DECIDE, ST_SQRT,
      ST_SCX, ST_DIVIX, ST_DIVX, ST_STX, ST_SCY, ST_DIVIY, ST_DIVY, ST_STY, ST_FIN
   } state_type;

   state_type                          state_ff, state_in;
   logic [wfv_pkg::STEP_CNT_W-1:0]     cnt_ff, cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   wfv_pkg::dp_op_type                 op;
   logic                               out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign cmd.op    = op;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      op           = wfv_pkg::OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd) begin
                  op       = wfv_pkg::OP_TICK;
                  state_in = ST_DIFF;
               end else begin
                  op = wfv_pkg::OP_LOAD;
               end
            end
         end
         ST_DIFF: begin
            op       = wfv_pkg::OP_DIFF;
            state_in = status.hover ? ST_FIN : ST_SQX;
         end
         ST_SQX: begin
            op       = wfv_pkg::OP_SQ_X;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            op       = wfv_pkg::OP_SQ_Y;
            state_in = ST_SQR;
         end
         ST_SQR: begin
            op       = wfv_pkg::OP_SQ_R;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            op       = wfv_pkg::OP_CMP;
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            op     = wfv_pkg::OP_SQRT_INIT;
            cnt_in = '0;
            state_in = (status.near || status.zero) ? ST_FIN : ST_SQRT;
         end
         ST_SQRT: begin
            op     = wfv_pkg::OP_SQRT_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == wfv_pkg::SQRT_STEPS - 1'b1) state_in = ST_SCX;
         end
         ST_SCX: begin
            op       = wfv_pkg::OP_SCALE_X;
            state_in = ST_DIVIX;
         end
         ST_DIVIX: begin
            op       = wfv_pkg::OP_DIV_INIT;
            cnt_in   = '0;
            state_in = ST_DIVX;
         end
         ST_DIVX: begin
            op     = wfv_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == wfv_pkg::DIV_STEPS - 1'b1) state_in = ST_STX;
         end
         ST_STX: begin
            op       = wfv_pkg::OP_STORE_X;
            state_in = ST_SCY;
         end
         ST_SCY: begin
            op       = wfv_pkg::OP_SCALE_Y;
            state_in = ST_DIVIY;
         end
         ST_DIVIY: begin
            op       = wfv_pkg::OP_DIV_INIT;
            cnt_in   = '0;
            state_in = ST_DIVY;
         end
         ST_DIVY: begin
            op     = wfv_pkg::OP_DIV_STEP;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == wfv_pkg::DIV_STEPS - 1'b1) state_in = ST_STY;
         end
         ST_STY: begin
            op       = wfv_pkg::OP_STORE_Y;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            // hold until the output register is free
            if (out_free) begin
               op           = wfv_pkg::OP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/wfv_datapath.sv
module wfv_datapath #(
   parameter int MAX_WAYPOINTS = wfv_pkg::MAX_WAYPOINTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  wfv_pkg::dp_cmd_type               cmd,
   output wfv_pkg::dp_status_type            status,
   input  logic signed [wfv_pkg::POS_W-1:0]  req_point_x,
   input  logic signed [wfv_pkg::POS_W-1:0]  req_point_y,
   input  logic                              req_path_start,
   input  logic                              csr_valid,
   input  logic                              csr_index,
   input  logic [wfv_pkg::CSR_W-1:0]         csr_data,
   output logic signed [wfv_pkg::VEL_W-1:0]  rsp_vel_x,
   output logic signed [wfv_pkg::VEL_W-1:0]  rsp_vel_y,
   output logic [1:0]                        rsp_nav_status,
   output logic [wfv_pkg::IDX_W-1:0]         rsp_target_index
);

   localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int PW = $clog2(MAX_WAYPOINTS + 1);
   localparam int IW = (PW > wfv_pkg::IDX_W) ? PW : wfv_pkg::IDX_W;
   localparam int EW = 2 * wfv_pkg::POS_W;
   localparam int SW = wfv_pkg::SQ_W;
   localparam int NW = wfv_pkg::NUM_W;
   localparam int QW = wfv_pkg::QUO_W;

   logic [EW-1:0] mem [MAX_WAYPOINTS];
   logic [EW-1:0] rd_ff;

   logic [PW-1:0] len_ff, ptr_ff;
   logic          fb0_ff, fb1_ff;
   logic [wfv_pkg::RAD_W-1:0] radius_ff;
   logic [wfv_pkg::SPD_W-1:0] speed_ff;

   logic [wfv_pkg::POS_W-1:0]  px_ff, py_ff;
   logic                       hover_ff, near_ff, zero_ff;
   logic [wfv_pkg::DIFF_W-1:0] ax_ff, ay_ff;
   logic                       sx_ff, sy_ff;
   logic [SW-1:0]              prod_ff, s_ff, n_ff, root_ff, bit_ff;
   logic [NW-1:0]              num_ff, dsh_ff;
   logic [QW-1:0]              quo_ff, vx_ff, vy_ff;

   logic [wfv_pkg::VEL_W-1:0]  out_vx_ff, out_vy_ff;
   logic [1:0]                 out_st_ff;
   logic [wfv_pkg::IDX_W-1:0]  out_idx_ff;

   wfv_pkg::dp_op_type op;
   assign op = cmd.op;

   // load address
   logic [PW-1:0] base;
   logic          full;
   assign base = req_path_start ? '0 : len_ff;
   assign full = (base == PW'(MAX_WAYPOINTS));

   // target select with fallback route
   logic [wfv_pkg::POS_W-1:0]  tx, ty;
   logic [wfv_pkg::DIFF_W-1:0] dx, dy;
   always_comb begin
      tx = rd_ff[EW-1:wfv_pkg::POS_W];
      ty = rd_ff[wfv_pkg::POS_W-1:0];
      if (ptr_ff == PW'(0) && fb0_ff) begin
         tx = wfv_pkg::FB0_X;
         ty = wfv_pkg::FB_Y;
      end else if (ptr_ff == PW'(1) && fb1_ff) begin
         tx = wfv_pkg::FB1_X;
         ty = wfv_pkg::FB_Y;
      end
   end
   assign dx = {tx[wfv_pkg::POS_W-1], tx} - {px_ff[wfv_pkg::POS_W-1], px_ff};
   assign dy = {ty[wfv_pkg::POS_W-1], ty} - {py_ff[wfv_pkg::POS_W-1], py_ff};

   // shared multiplier
   logic [wfv_pkg::DIFF_W-1:0] mul_a, mul_b;
   logic [SW-1:0]              prod_in;
   always_comb begin
      mul_a = ax_ff;
      mul_b = ax_ff;
      case (op)
         wfv_pkg::OP_SQ_Y: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         wfv_pkg::OP_SQ_R: begin
            mul_a = wfv_pkg::DIFF_W'(radius_ff);
            mul_b = wfv_pkg::DIFF_W'(radius_ff);
         end
         wfv_pkg::OP_SCALE_X: begin
            mul_a = wfv_pkg::DIFF_W'(speed_ff);
            mul_b = ax_ff;
         end
         wfv_pkg::OP_SCALE_Y: begin
            mul_a = wfv_pkg::DIFF_W'(speed_ff);
            mul_b = ay_ff;
         end
         default: ;
      endcase
   end
   assign prod_in = mul_a * mul_b;

   // square root step
   logic [SW:0] trial;
   assign trial = {1'b0, root_ff} + {1'b0, bit_ff};

   logic [wfv_pkg::ROOT_W-1:0] q;
   assign q = root_ff[wfv_pkg::ROOT_W-1:0];

   logic [PW-1:0] ptr_next;
   logic [IW-1:0] idx_cur, idx_next;
   assign ptr_next = ptr_ff + 1'b1;
   assign idx_cur  = IW'(ptr_ff);
   assign idx_next = IW'(ptr_next);

   always_ff @(posedge clock) begin
      if (op == wfv_pkg::OP_LOAD && !full) mem[base[AW-1:0]] <= {req_point_x, req_point_y};
      if (op == wfv_pkg::OP_TICK) rd_ff <= mem[ptr_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= PW'(2);
         ptr_ff     <= '0;
         fb0_ff     <= 1'b1;
         fb1_ff     <= 1'b1;
         radius_ff  <= wfv_pkg::RADIUS_RESET;
         speed_ff   <= wfv_pkg::SPEED_RESET;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               wfv_pkg::CSR_ARRIVAL_RADIUS: radius_ff <= csr_data;
               wfv_pkg::CSR_CRUISE_SPEED:   speed_ff  <= csr_data[wfv_pkg::SPD_W-1:0];
               default: ;
            endcase
         end
         if (op == wfv_pkg::OP_LOAD) begin
            if (req_path_start) ptr_ff <= '0;
            if (!full) begin
               len_ff <= base + 1'b1;
               if (base == PW'(0)) fb0_ff <= 1'b0;
               if (base == PW'(1)) fb1_ff <= 1'b0;
            end
         end
         if (op == wfv_pkg::OP_RESULT && !hover_ff && near_ff) ptr_ff <= ptr_next;
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         wfv_pkg::OP_TICK: begin
            px_ff    <= req_point_x;
            py_ff    <= req_point_y;
            hover_ff <= (ptr_ff >= len_ff);
            near_ff  <= 1'b0;
            zero_ff  <= 1'b0;
         end
         wfv_pkg::OP_DIFF: begin
            sx_ff <= dx[wfv_pkg::DIFF_W-1];
            sy_ff <= dy[wfv_pkg::DIFF_W-1];
            ax_ff <= dx[wfv_pkg::DIFF_W-1] ? -dx : dx;
            ay_ff <= dy[wfv_pkg::DIFF_W-1] ? -dy : dy;
         end
         wfv_pkg::OP_SQ_X: prod_ff <= prod_in;
         wfv_pkg::OP_SQ_Y: begin
            prod_ff <= prod_in;
            s_ff    <= prod_ff;
         end
         wfv_pkg::OP_SQ_R: begin
            prod_ff <= prod_in;
            s_ff    <= s_ff + prod_ff;
         end
         wfv_pkg::OP_CMP: begin
            near_ff <= (s_ff < prod_ff);
            zero_ff <= (s_ff == '0);
         end
         wfv_pkg::OP_SQRT_INIT: begin
            n_ff    <= s_ff;
            root_ff <= '0;
            bit_ff  <= SW'(1) << (SW - 2);
         end
         wfv_pkg::OP_SQRT_STEP: begin
            if ({1'b0, n_ff} >= trial) begin
               n_ff    <= n_ff - trial[SW-1:0];
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         wfv_pkg::OP_SCALE_X, wfv_pkg::OP_SCALE_Y: prod_ff <= prod_in;
         wfv_pkg::OP_DIV_INIT: begin
            // round to nearest: (2*v*|d| + q) / (2*q), quotient fits 16 bits
            num_ff <= NW'({prod_ff, 1'b0}) + NW'(q);
            dsh_ff <= NW'({q, 1'b0}) << (QW - 1);
            quo_ff <= '0;
         end
         wfv_pkg::OP_DIV_STEP: begin
            if (num_ff >= dsh_ff) begin
               num_ff <= num_ff - dsh_ff;
               quo_ff <= {quo_ff[QW-2:0], 1'b1};
            end else begin
               quo_ff <= {quo_ff[QW-2:0], 1'b0};
            end
            dsh_ff <= dsh_ff >> 1;
         end
         wfv_pkg::OP_STORE_X: vx_ff <= sx_ff ? (~quo_ff + 1'b1) : quo_ff;
         wfv_pkg::OP_STORE_Y: vy_ff <= sy_ff ? (~quo_ff + 1'b1) : quo_ff;
         wfv_pkg::OP_RESULT: begin
            out_vx_ff  <= '0;
            out_vy_ff  <= '0;
            out_idx_ff <= idx_cur[wfv_pkg::IDX_W-1:0];
            if (hover_ff) begin
               out_st_ff <= wfv_pkg::NAV_DONE;
            end else if (near_ff) begin
               out_st_ff  <= wfv_pkg::NAV_REACHED;
               out_idx_ff <= idx_next[wfv_pkg::IDX_W-1:0];
            end else begin
               out_st_ff <= wfv_pkg::NAV_MOVING;
               if (!zero_ff) begin
                  out_vx_ff <= vx_ff;
                  out_vy_ff <= vy_ff;
               end
            end
         end
         default: ;
      endcase
   end

   assign status.hover = hover_ff;
   assign status.near  = near_ff;
   assign status.zero  = zero_ff;

   assign rsp_vel_x        = $signed(out_vx_ff);
   assign rsp_vel_y        = $signed(out_vy_ff);
   assign rsp_nav_status   = out_st_ff;
   assign rsp_target_index = out_idx_ff;

endmodule

FILE: rtl/core/waypoint_follower_velocity_core.sv
// channel | direction | ports
// req     | in        | req_valid/req_ready, req_cmd, req_point_x, req_point_y, req_path_start
// rsp     | out       | rsp_valid/rsp_ready, rsp_vel_x, rsp_vel_y, rsp_nav_status,
//         |           | rsp_target_index
// csr     | in        | csr_valid/csr_ready, csr_index, csr_data
//
// A load request gives no response. A moving tick runs 25 square root steps and two
// 16 step divisions on one shared unit; it skips them when the waypoint is reached or
// the distance is zero, skips the squares too when hovering, and may wait on rsp_ready.
// Synchronous reset restores the fallback route; the route table itself is not cleared.
// A held response does not block loads; a following tick waits only at its end.
module waypoint_follower_velocity_core #(
   parameter int MAX_WAYPOINTS = wfv_pkg::MAX_WAYPOINTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_cmd,
   input  logic signed [wfv_pkg::POS_W-1:0]  req_point_x,
   input  logic signed [wfv_pkg::POS_W-1:0]  req_point_y,
   input  logic                              req_path_start,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [wfv_pkg::VEL_W-1:0]  rsp_vel_x,
   output logic signed [wfv_pkg::VEL_W-1:0]  rsp_vel_y,
   output logic [1:0]                        rsp_nav_status,
   output logic [wfv_pkg::IDX_W-1:0]         rsp_target_index,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [wfv_pkg::CSR_W-1:0]         csr_data
);

   wfv_pkg::dp_cmd_type    cmd;
   wfv_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   wfv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   wfv_datapath #(
      .MAX_WAYPOINTS (MAX_WAYPOINTS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_path_start   (req_path_start),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_vel_x        (rsp_vel_x),
      .rsp_vel_y        (rsp_vel_y),
      .rsp_nav_status   (rsp_nav_status),
      .rsp_target_index (rsp_target_index)
   );

endmodule

FILE: tb/waypoint_follower_velocity_core_tb.sv
`timescale 1ns / 1ps

module waypoint_follower_velocity_core_tb;

   localparam int DEPTH = wfv_pkg::MAX_WAYPOINTS_DEF;
   localparam int STALL_LIMIT = 20000;

   typedef struct {
      logic signed [wfv_pkg::VEL_W-1:0] vel_x;
      logic signed [wfv_pkg::VEL_W-1:0] vel_y;
      wfv_pkg::nav_status_type          status;
      logic [wfv_pkg::IDX_W-1:0]        index;
   } nav_cmd_type;

   logic clock = 0;
   logic reset;
   logic req_valid, req_ready, req_cmd, req_path_start;
   logic signed [wfv_pkg::POS_W-1:0] req_point_x, req_point_y;
   logic rsp_valid, rsp_ready;
   logic signed [wfv_pkg::VEL_W-1:0] rsp_vel_x, rsp_vel_y;
   logic [1:0] rsp_nav_status;
   logic [wfv_pkg::IDX_W-1:0] rsp_target_index;
   logic csr_valid, csr_ready, csr_index;
   logic [wfv_pkg::CSR_W-1:0] csr_data;

   int error_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_rsp = 0;
   int n_ticks = 0, n_loads = 0, n_reached = 0, n_done = 0, n_moving = 0;

   waypoint_follower_velocity_core dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   class nav_scoreboard;
      logic signed [31:0] route_x[DEPTH];
      logic signed [31:0] route_y[DEPTH];
      int unsigned route_len;
      int unsigned target_ptr;
      logic [wfv_pkg::RAD_W-1:0] radius;
      logic [wfv_pkg::SPD_W-1:0] speed;
      nav_cmd_type pending[$];

      function new();
         foreach (route_x[i]) begin
            route_x[i] = 0;
            route_y[i] = 0;
         end
         route_x[0] = 4 * 256;
         route_y[0] = 26 * 256;
         route_x[1] = 8 * 256;
         route_y[1] = 26 * 256;
         route_len = 2;
         target_ptr = 0;
         radius = wfv_pkg::RADIUS_RESET;
         speed = wfv_pkg::SPEED_RESET;
      endfunction

      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned root = 0;
         longint unsigned b = 64'd1 << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= root + b) begin
               n -= root + b;
               root = (root >> 1) + b;
            end else begin
               root >>= 1;
            end
            b >>= 2;
         end
         return root;
      endfunction

      function logic signed [wfv_pkg::VEL_W-1:0] axis_velocity(longint d, longint unsigned q);
         longint unsigned mag = (d < 0) ? -d : d;
         longint unsigned v = (2 * longint'(speed) * mag + q) / (2 * q);
         longint s;
         if (v > 32768) v = 32768;
         s = (d < 0) ? -longint'(v) : longint'(v);
         if (s > 32767) s = 32767;
         return s[wfv_pkg::VEL_W-1:0];
      endfunction

      function void note_request(logic cmd, logic signed [wfv_pkg::POS_W-1:0] px,
                                 logic signed [wfv_pkg::POS_W-1:0] py, logic start);
         nav_cmd_type e;
         longint dx, dy;
         longint unsigned s, r2, q;
         if (!cmd) begin
            if (start) begin
               route_len = 0;
               target_ptr = 0;
            end
            if (route_len < DEPTH) begin
               route_x[route_len] = px;
               route_y[route_len] = py;
               route_len++;
            end
            return;
         end
         e.vel_x = 0;
         e.vel_y = 0;
         e.status = wfv_pkg::NAV_MOVING;
         if (target_ptr >= route_len) begin
            e.status = wfv_pkg::NAV_DONE;
         end else begin
            dx = longint'(route_x[target_ptr]) - longint'(px);
            dy = longint'(route_y[target_ptr]) - longint'(py);
            s = dx * dx + dy * dy;
            r2 = longint'(radius) * longint'(radius);
            if (s < r2) begin
               target_ptr++;
               e.status = wfv_pkg::NAV_REACHED;
            end else if (s != 0) begin
               q = int_sqrt(s);
               e.vel_x = axis_velocity(dx, q);
               e.vel_y = axis_velocity(dy, q);
            end
         end
         e.index = target_ptr[wfv_pkg::IDX_W-1:0];
         pending = {pending, e};
      endfunction

      task check_response(logic signed [wfv_pkg::VEL_W-1:0] vx,
                          logic signed [wfv_pkg::VEL_W-1:0] vy,
                          logic [1:0] st, logic [wfv_pkg::IDX_W-1:0] idx);
         nav_cmd_type e;
         if (pending.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
            return;
         end
         e = pending.pop_front();
         if (vx !== e.vel_x) report_mismatch("vel_x", vx, e.vel_x);
         if (vy !== e.vel_y) report_mismatch("vel_y", vy, e.vel_y);
         if (st !== e.status) report_mismatch("nav_status", st, e.status);
         if (idx !== e.index) report_mismatch("target_index", idx, e.index);
      endtask
   endclass

   nav_scoreboard sb = new();

   // request/response/config monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_request(req_cmd, req_point_x, req_point_y, req_path_start);
            if (req_cmd) n_ticks++;
            else n_loads++;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == wfv_pkg::CSR_ARRIVAL_RADIUS)
               sb.radius = csr_data[wfv_pkg::RAD_W-1:0];
            else sb.speed = csr_data[wfv_pkg::SPD_W-1:0];
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_vel_x, rsp_vel_y, rsp_nav_status, rsp_target_index);
            case (rsp_nav_status)
               wfv_pkg::NAV_REACHED: n_reached++;
               wfv_pkg::NAV_DONE:    n_done++;
               default:              n_moving++;
            endcase
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("waypoint_follower_velocity_core_tb: errors");
            $finish;
         end
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_request(input logic cmd, input logic signed [wfv_pkg::POS_W-1:0] px,
                               input logic signed [wfv_pkg::POS_W-1:0] py, input logic start);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid = 1'b1;
      req_cmd = cmd;
      req_point_x = px;
      req_point_y = py;
      req_path_start = start;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_csr(input logic idx, input logic [wfv_pkg::CSR_W-1:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   function automatic logic signed [wfv_pkg::POS_W-1:0] near_offset(logic signed [31:0] base,
                                                                   int span);
      return wfv_pkg::POS_W'(base + $signed($urandom_range(2 * span)) - span);
   endfunction

   function automatic logic signed [wfv_pkg::POS_W-1:0] any_pos();
      return wfv_pkg::POS_W'($urandom());
   endfunction

   // random point: mostly modest range, sometimes full range
   function automatic logic signed [wfv_pkg::POS_W-1:0] route_pos();
      if ($urandom_range(9) == 0) return any_pos();
      return wfv_pkg::POS_W'($signed($urandom_range(20000)) - 10000);
   endfunction

   task automatic run_route(input int n_items);
      int len, k;
      logic signed [wfv_pkg::POS_W-1:0] px, py;
      while (n_items > 0) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
         for (k = 0; k < len; k++) begin
            send_request(1'b0, route_pos(), route_pos(), k == 0);
            n_items--;
         end
         // follow the route: ticks near or far from the current target
         for (k = 0; k < 3 * len + 2 && k < 24; k++) begin
            if (sb.target_ptr < sb.route_len && $urandom_range(2) != 0) begin
               px = near_offset(sb.route_x[sb.target_ptr], sb.radius + 4);
               py = near_offset(sb.route_y[sb.target_ptr], sb.radius + 4);
            end else begin
               px = ($urandom_range(3) == 0) ? any_pos() : route_pos();
               py = ($urandom_range(3) == 0) ? any_pos() : route_pos();
            end
            // noise: occasional stray load or path_start on a tick
            if ($urandom_range(19) == 0)
               send_request(1'b0, any_pos(), any_pos(), 1'($urandom_range(1)));
            else
               send_request(1'b1, px, py, 1'($urandom_range(1)));
            n_items--;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 0; req_cmd = 0; req_point_x = 0; req_point_y = 0; req_path_start = 0;
      csr_valid = 0; csr_index = 0; csr_data = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: fallback route, reach both points, hover, append to fallback
      send_request(1'b1, 24'sd0, 24'sd0, 1'b0);
      send_request(1'b1, 24'sd1024, 24'sd6656, 1'b0);
      send_request(1'b1, 24'sd2048 + 24'sd20, 24'sd6656, 1'b0);
      send_request(1'b1, 24'sd0, 24'sd0, 1'b0);
      send_request(1'b0, 24'sd100, 24'sd100, 1'b0);
      send_request(1'b1, 24'sd0, 24'sd0, 1'b0);
      // extremes of position with saturation-prone speed
      drain();
      write_csr(wfv_pkg::CSR_CRUISE_SPEED, 16'h7FFF);
      write_csr(wfv_pkg::CSR_ARRIVAL_RADIUS, 16'hFFFF);
      send_request(1'b0, 24'sh7FFFFF, 24'sh7FFFFF, 1'b1);
      send_request(1'b0, -24'sh800000, 24'sh7FFFFF, 1'b0);
      send_request(1'b1, -24'sh800000, -24'sh800000, 1'b0);
      send_request(1'b1, 24'sh7FFFFF, -24'sh800000, 1'b0);
      send_request(1'b1, -24'sh800000, 24'sh7FFFFF, 1'b0);
      send_request(1'b1, 24'sd0, 24'sd0, 1'b0);
      drain();
      // zero radius, zero distance
      write_csr(wfv_pkg::CSR_ARRIVAL_RADIUS, 16'h0000);
      write_csr(wfv_pkg::CSR_CRUISE_SPEED, 16'h0000);
      send_request(1'b0, 24'sd5, -24'sd5, 1'b1);
      send_request(1'b1, 24'sd5, -24'sd5, 1'b0);
      send_request(1'b1, 24'sd0, 24'sd0, 1'b0);
      drain();
      // table overflow: 66 loads, the last two dropped
      write_csr(wfv_pkg::CSR_ARRIVAL_RADIUS, wfv_pkg::RADIUS_RESET);
      write_csr(wfv_pkg::CSR_CRUISE_SPEED, 16'h7FFF);
      for (int i = 0; i < 66; i++)
         send_request(1'b0, wfv_pkg::POS_W'(i * 1000), wfv_pkg::POS_W'(-i * 1000), i == 0);
      send_request(1'b1, 24'sd0, 24'sd0, 1'b0);
      send_request(1'b1, 24'sd1, 24'sd0, 1'b0);

      // long receiver hold-off while requests keep coming
      hold_rsp = 1'b1;
      fork
         begin
            repeat (600) @(negedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 6; i++) send_request(1'b1, route_pos(), route_pos(), 1'b0);
      join
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 73 : 0;
         recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 6 : 0;
         for (int c = 0; c < 3; c++) begin
            case ($urandom_range(3))
               0: write_csr(wfv_pkg::CSR_ARRIVAL_RADIUS,
                            wfv_pkg::CSR_W'($urandom_range(1, 65535)));
               1: write_csr(wfv_pkg::CSR_ARRIVAL_RADIUS,
                            wfv_pkg::CSR_W'($urandom_range(20, 2000)));
               2: write_csr(wfv_pkg::CSR_CRUISE_SPEED,
                            wfv_pkg::CSR_W'($urandom_range(32767)));
               default: write_csr(wfv_pkg::CSR_CRUISE_SPEED,
                                  wfv_pkg::CSR_W'($urandom_range(1, 8192)));
            endcase
            run_route(120);
            drain();
         end
      end

      drain();
      $display("covered %0d loads and %0d ticks: %0d moving, %0d reached, %0d hovering",
               n_loads, n_ticks, n_moving, n_reached, n_done);
      $display("config phases with radius/speed extremes, overflow, backpressure and gaps");
      if (error_count == 0)
         $display("waypoint_follower_velocity_core_tb: clean");
      else
         $display("waypoint_follower_velocity_core_tb: errors");
      $finish;
   end

endmodule

FILE: waypoint_follower_velocity_core.f
rtl/core/wfv_pkg.sv
rtl/core/wfv_ctrl.sv
rtl/core/wfv_datapath.sv
rtl/core/waypoint_follower_velocity_core.sv
tb/waypoint_follower_velocity_core_tb.sv
